// ===== src/pzb_pkg.sv =====
// Shared types, codes and constants for the perspective depth-buffer block.
package pzb_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_COORD_BITS = 16;

  // Depth codes: all ones marks an empty entry, distances saturate one below it.
  localparam logic [15:0] INFINITY = 16'hFFFF;
  localparam logic [15:0] DIST_MAX = 16'hFFFE;

  // Register reset values.
  localparam logic [15:0] RST_PROJ = 16'd2560;
  localparam logic [14:0] RST_PUSH = 15'd5120;
  localparam logic [6:0]  RST_ROWS = 7'd64;
  localparam logic [7:0]  RST_COLS = 8'd128;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    REG_PROJ = 8'd0,
    REG_PUSH = 8'd1,
    REG_ROWS = 8'd2,
    REG_COLS = 8'd3
  } reg_idx_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_READ   = 3'd0,
    ST_STORED = 3'd1,
    ST_HIDDEN = 3'd2,
    ST_OFF    = 3'd3,
    ST_ZERO   = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_RDW,
    S_MUL,
    S_DIVSET,
    S_DIV,
    S_SQRT,
    S_LOOK,
    S_LOOKW,
    S_DONE
  } state_e;

endpackage

// ===== src/pzb_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module pzb_sqrt #(
  parameter int RW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] rad_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);
  import pzb_pkg::*;

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;
  logic            ge;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_q, rad_q[2*RW-1 -: 2]};
    trial  = (RW + 4)'({root_q, 2'b01});
    ge     = (rem_sh >= trial);
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  // Remainder and root registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? (RW + 2)'(rem_sh - trial) : (RW + 2)'(rem_sh);
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== src/perspective_zbuffer_top.sv =====
// Perspective projection of 3D points into a depth buffer that keeps the nearest distance.
// A plot runs the multiply steps, divides for the column then the row, waits for the square
// root and does a read-compare-write of the store (off screen no store access, at zero depth
// no divides either); a read in range reads the store. One item at a time: input is ready
// again as the result becomes valid, or later while a finished result waits for transfer.
// Reset sets control and config registers, then writes the empty mark, one entry per cycle.
module perspective_zbuffer_top #(
  parameter int MAX_ROWS   = pzb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = pzb_pkg::DEF_MAX_COLS,
  parameter int COORD_BITS = pzb_pkg::DEF_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [7:0]                   cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic [5:0]                   read_row_i,
  input  logic [6:0]                   read_col_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   status_o,
  output logic [15:0]                  depth_value_o,
  output logic [5:0]                   pixel_row_o,
  output logic [6:0]                   pixel_col_o
);
  import pzb_pkg::*;

  localparam int PZW   = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
  localparam int MW    = PZW + 1;
  localparam int PW    = 2 * MW;
  localparam int RW    = PZW + 1;
  localparam int NW    = PZW + 20;
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int QW    = $clog2(MAXD + 1);
  localparam int DVW   = NW + QW;
  localparam int DCW   = $clog2(QW + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  state_e state_q, state_d;

  logic [15:0] proj_q;
  logic [14:0] push_q;
  logic [6:0]  rows_q;
  logic [7:0]  cols_q;
  logic [QW-1:0] rows_lim, cols_lim, hr, hc;

  logic signed [PZW-1:0] x_q, y_q, pz_q;
  logic [PZW-1:0]        pz_mag;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod, prod_q;
  logic [2:0]            mstep_q;
  logic [PW-1:0]         sum_q;
  logic signed [NW-1:0]  numc_q, numr_q, num_sel;
  logic [NW-1:0]         num_mag;

  logic            sel_q;
  logic [DVW-1:0]  rem_q, dsh_q;
  logic [QW-1:0]   quo_q, quo_nx, lim;
  logic            ovf_q, ovf_nx, neg_q, ge, axis_ok;
  logic [DCW-1:0]  dcnt_q;
  logic            first_step, last_step;
  logic [QW-1:0]   col_q, row_q;
  logic            col_ok_q, row_ok_q;

  logic [AW-1:0] addr_q, clr_q;
  logic [15:0]   depth_mem [0:DEPTH-1];
  logic [15:0]   mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  logic          sqrt_start, sqrt_done;
  logic [RW-1:0] sqrt_root;
  logic [15:0]   dist_q;
  logic          dist_rdy_q;

  status_e     res_status_q, out_status_q;
  logic [15:0] res_depth_q, out_depth_q;
  logic [5:0]  res_row_q, out_row_q;
  logic [6:0]  res_col_q, out_col_q;
  logic        out_valid_q;

  logic accept, rd_in_range, pz_zero, out_free;

  assign accept      = in_valid_i && in_ready_o;
  assign rd_in_range = (32'(read_row_i) < MAX_ROWS) && (32'(read_col_i) < MAX_COLS);
  assign pz_zero     = (pz_q == '0);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_q <= RST_PROJ;
      push_q <= RST_PUSH;
      rows_q <= RST_ROWS;
      cols_q <= RST_COLS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PROJ: proj_q <= cfg_data_i;
        REG_PUSH: push_q <= cfg_data_i[14:0];
        REG_ROWS: rows_q <= cfg_data_i[6:0];
        REG_COLS: cols_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Screen size clamped to the store (zero taken as one), and the screen centre.
  always_comb begin
    if (rows_q == '0) rows_lim = QW'(1);
    else if (32'(rows_q) > MAX_ROWS) rows_lim = QW'(MAX_ROWS);
    else rows_lim = QW'(rows_q);
    if (cols_q == '0) cols_lim = QW'(1);
    else if (32'(cols_q) > MAX_COLS) cols_lim = QW'(MAX_COLS);
    else cols_lim = QW'(cols_q);
    hr = rows_lim >> 1;
    hc = cols_lim >> 1;
  end

  // Shared multiplier operand selection, one product per step.
  always_comb begin
    case (mstep_q)
      3'd0: begin mul_a = MW'(x_q);  mul_b = MW'(x_q);  end
      3'd1: begin mul_a = MW'(y_q);  mul_b = MW'(y_q);  end
      3'd2: begin mul_a = MW'(pz_q); mul_b = MW'(pz_q); end
      3'd3: begin mul_a = MW'(x_q);  mul_b = MW'($signed({1'b0, proj_q})); end
      3'd4: begin mul_a = MW'($signed({1'b0, hc})); mul_b = MW'(pz_q); end
      3'd5: begin mul_a = MW'(y_q);  mul_b = MW'($signed({1'b0, proj_q})); end
      3'd6: begin mul_a = MW'($signed({1'b0, hr})); mul_b = MW'(pz_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
  end

  // Divider step: magnitudes in, one quotient bit per cycle after an overflow check.
  always_comb begin
    num_sel    = sel_q ? numr_q : numc_q;
    num_mag    = num_sel[NW-1] ? NW'(-num_sel) : NW'(num_sel);
    pz_mag     = pz_q[PZW-1] ? PZW'(-pz_q) : PZW'(pz_q);
    ge         = (rem_q >= dsh_q);
    first_step = (dcnt_q == DCW'(QW));
    last_step  = (dcnt_q == '0);
    quo_nx     = first_step ? quo_q : {quo_q[QW-2:0], ge};
    ovf_nx     = first_step ? ge : ovf_q;
    lim        = sel_q ? rows_lim : cols_lim;
    axis_ok    = !ovf_nx && ((quo_nx == '0) || !neg_q) && (quo_nx < lim);
  end

  pzb_sqrt #(
    .RW(RW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .rad_i  (sum_q),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i) state_d = rd_in_range ? S_RD : S_DONE;
          else state_d = S_MUL;
        end
      end
      S_RD:     state_d = S_RDW;
      S_RDW:    state_d = S_DONE;
      S_MUL:    if (mstep_q == 3'd7) state_d = pz_zero ? S_SQRT : S_DIVSET;
      S_DIVSET: state_d = S_DIV;
      S_DIV:    if (last_step) state_d = sel_q ? S_SQRT : S_DIVSET;
      S_SQRT: begin
        if (dist_rdy_q) begin
          state_d = (pz_zero || !(col_ok_q && row_ok_q)) ? S_DONE : S_LOOK;
        end
      end
      S_LOOK:   state_d = S_LOOKW;
      S_LOOKW:  state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Output and strobe logic of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = INFINITY;
    sqrt_start = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      S_IDLE:  in_ready_o = 1'b1;
      S_RDW:   mem_we = 1'b1;
      S_MUL:   sqrt_start = (mstep_q == 3'd4);
      S_LOOKW: begin
        mem_we    = (mem_rdata_q > dist_q);
        mem_wdata = dist_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mstep_q     <= '0;
      dcnt_q      <= '0;
      sel_q       <= 1'b0;
      dist_rdy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (accept) begin
        mstep_q    <= '0;
        sel_q      <= 1'b0;
        dist_rdy_q <= 1'b0;
      end
      if (state_q == S_MUL) mstep_q <= mstep_q + 1'b1;
      if (state_q == S_DIVSET) dcnt_q <= DCW'(QW);
      if (state_q == S_DIV) begin
        dcnt_q <= dcnt_q - 1'b1;
        if (last_step) sel_q <= 1'b1;
      end
      if (sqrt_done) dist_rdy_q <= 1'b1;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q  <= PZW'(pos_x_i);
      y_q  <= PZW'(pos_y_i);
      pz_q <= PZW'(pos_z_i) - $signed({{(PZW - 15){1'b0}}, push_q});
      if (kind_i) begin
        res_status_q <= ST_READ;
        res_depth_q  <= INFINITY;
        res_row_q    <= read_row_i;
        res_col_q    <= read_col_i;
        addr_q       <= AW'(AW'(read_row_i) * AW'(MAX_COLS) + AW'(read_col_i));
      end
    end

    // Squares accumulate into the radicand, the projection numerators follow.
    if (state_q == S_MUL) begin
      prod_q <= prod;
      case (mstep_q)
        3'd1: sum_q <= $unsigned(prod_q);
        3'd2: sum_q <= sum_q + $unsigned(prod_q);
        3'd3: sum_q <= sum_q + $unsigned(prod_q);
        3'd4: numc_q <= -(NW'(prod_q));
        3'd5: numc_q <= numc_q + (NW'(prod_q) <<< 8);
        3'd6: numr_q <= -(NW'(prod_q));
        3'd7: numr_q <= numr_q + (NW'(prod_q) <<< 8);
        default: ;
      endcase
    end

    if (state_q == S_DIVSET) begin
      rem_q <= DVW'(num_mag);
      dsh_q <= DVW'(pz_mag) << (8 + QW);
      quo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_sel[NW-1] ^ pz_q[PZW-1];
    end

    if (state_q == S_DIV) begin
      if (!first_step && ge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= quo_nx;
      ovf_q <= ovf_nx;
      if (last_step) begin
        if (sel_q) begin
          row_q    <= quo_nx;
          row_ok_q <= axis_ok;
          addr_q   <= AW'(AW'(quo_nx) * AW'(MAX_COLS) + AW'(col_q));
        end else begin
          col_q    <= quo_nx;
          col_ok_q <= axis_ok;
        end
      end
    end

    // Distance saturates one below the empty mark.
    if (sqrt_done) begin
      dist_q <= (sqrt_root > RW'(DIST_MAX)) ? DIST_MAX : sqrt_root[15:0];
    end

    if (state_q == S_SQRT && dist_rdy_q) begin
      res_depth_q <= dist_q;
      if (pz_zero) begin
        res_status_q <= ST_ZERO;
        res_row_q    <= '0;
        res_col_q    <= '0;
      end else if (!(col_ok_q && row_ok_q)) begin
        res_status_q <= ST_OFF;
        res_row_q    <= '0;
        res_col_q    <= '0;
      end else begin
        res_row_q <= 6'(row_q);
        res_col_q <= 7'(col_q);
      end
    end

    if (state_q == S_RDW) res_depth_q <= mem_rdata_q;
    if (state_q == S_LOOKW) begin
      res_status_q <= (mem_rdata_q > dist_q) ? ST_STORED : ST_HIDDEN;
    end

    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_depth_q  <= res_depth_q;
      out_row_q    <= res_row_q;
      out_col_q    <= res_col_q;
    end
  end

  // Depth store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= depth_mem[addr_q];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign depth_value_o = out_depth_q;
  assign pixel_row_o   = out_row_q;
  assign pixel_col_o   = out_col_q;

endmodule

// ===== src/pzb_checker.sv =====
// Port-level checks for the depth-buffer block, bound to its top level.
module pzb_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [15:0] depth_value_o,
  input logic [5:0]  pixel_row_o,
  input logic [6:0]  pixel_col_o
);
  import pzb_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(depth_value_o))
    else $error("result changed while stalled");

  // One item at a time: no transfer in the cycle after a transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready straight after a transfer");

  // A stored distance never equals the empty mark.
  a_stored_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_STORED) |-> depth_value_o != INFINITY)
    else $error("stored distance equals the empty mark");

  // Off-screen and zero-depth results carry no pixel.
  a_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_OFF) || (status_o == ST_ZERO))
    |-> (pixel_row_o == '0) && (pixel_col_o == '0))
    else $error("pixel given for a result without one");

endmodule

bind perspective_zbuffer_top pzb_port_checker u_pzb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .depth_value_o(depth_value_o),
  .pixel_row_o  (pixel_row_o),
  .pixel_col_o  (pixel_col_o)
);
